// ===== rtl/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// sida_pkg
// Types and constants shared by the signed integer to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

  localparam int unsigned BIN_W           = 32;
  localparam int unsigned NUM_DIGITS      = 10;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned BCD_W           = NUM_DIGITS * DIGIT_W;
  localparam int unsigned NUM_STAGES      = 4;
  localparam int unsigned STEPS_PER_STAGE = BIN_W / NUM_STAGES;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic             neg;
    logic [BIN_W-1:0] bin;
    logic [BCD_W-1:0] bcd;
  } dab_t;

endpackage : sida_pkg

`default_nettype wire

// ===== rtl/sida_dabble.sv =====
// ----------------------------------------------------------------------------
// sida_dabble
// One pipeline stage of the binary to BCD conversion: eight shift-and-adjust
// steps, a data register with its valid bit, and stall handling.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_dabble
  import sida_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic up_vld,
  input  wire dab_t up_data,
  output logic      up_rdy,
  input  wire logic dn_rdy,
  output logic      vld_r,
  output dab_t      data_r
);

  dab_t data_nxt;

  always_comb begin
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
    bcd = up_data.bcd;
    bin = up_data.bin;
    for (int s = 0; s < int'(STEPS_PER_STAGE); s++) begin
      for (int d = 0; d < int'(NUM_DIGITS); d++) begin
        if (bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
          bcd[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
        end
      end
      {bcd, bin} = {bcd[BCD_W-2:0], bin, 1'b0};
    end
    data_nxt.neg = up_data.neg;
    data_nxt.bin = bin;
    data_nxt.bcd = bcd;
  end

  assign up_rdy = !vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data_r <= data_nxt;
    end
  end

endmodule : sida_dabble

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Data path: entry register, dabble stages, serializer, output register.
// Throughput: one character per cycle; a number is 1 to 11 characters
// (sign plus digits), sent by the character serializer at the output.
// The converter pipeline is 5 stages deep and buffers numbers while the
// serializer works; busy rises when it is full. The receiver cannot stall.
// Reset clears all valid bits and the serializer; no clearing pass.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Formats a signed 32-bit word as decimal ASCII text, one character a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  output logic             [7:0]  out_char_code,
  output logic                    out_last_char
);

  // entry stage: sign and magnitude
  logic             vld0_r;
  dab_t             data0_r;
  dab_t             data0_nxt;
  logic             rdy0;
  logic [BIN_W-1:0] val_u;

  logic             stg_vld [NUM_STAGES+1];
  dab_t             stg_data[NUM_STAGES+1];
  logic             stg_rdy [NUM_STAGES+1];

  // serializer
  logic                 act_r, act_nxt;
  logic                 sign_r, sign_nxt;
  logic [DIGIT_W-1:0]   idx_r, idx_nxt;
  digit_t               dig_r[NUM_DIGITS];
  logic [DIGIT_W-1:0]   lead;
  logic                 ser_free;
  logic                 ser_load;
  logic                 ov_nxt, ol_nxt;
  logic [7:0]           oc_nxt;
  logic                 out_valid_r, out_last_char_r;
  logic [7:0]           out_char_code_r;

  assign val_u         = $unsigned(in_value);
  assign data0_nxt.neg = val_u[BIN_W-1];
  assign data0_nxt.bin = val_u[BIN_W-1] ? (~val_u + 1'b1) : val_u;
  assign data0_nxt.bcd = '0;

  assign rdy0 = !vld0_r || stg_rdy[0];
  assign busy = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (rdy0) begin
      vld0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && start) begin
      data0_r <= data0_nxt;
    end
  end

  assign stg_vld[0]  = vld0_r;
  assign stg_data[0] = data0_r;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dab
    sida_dabble u_dab (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld  (stg_vld[g]),
      .up_data (stg_data[g]),
      .up_rdy  (stg_rdy[g]),
      .dn_rdy  (stg_rdy[g+1]),
      .vld_r   (stg_vld[g+1]),
      .data_r  (stg_data[g+1])
    );
  end

  assign ser_free           = !act_r || (!sign_r && idx_r == '0);
  assign stg_rdy[NUM_STAGES] = ser_free;
  assign ser_load           = ser_free && stg_vld[NUM_STAGES];

  always_comb begin
    lead = '0;
    for (int d = 0; d < int'(NUM_DIGITS); d++) begin
      if (stg_data[NUM_STAGES].bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        lead = DIGIT_W'(d);
      end
    end
  end

  always_comb begin
    act_nxt  = act_r;
    sign_nxt = sign_r;
    idx_nxt  = idx_r;
    ov_nxt   = 1'b0;
    oc_nxt   = out_char_code_r;
    ol_nxt   = 1'b0;
    if (act_r) begin
      ov_nxt = 1'b1;
      if (sign_r) begin
        oc_nxt   = CHAR_MINUS;
        sign_nxt = 1'b0;
      end else begin
        oc_nxt = CHAR_ZERO + {4'b0000, dig_r[idx_r]};
        ol_nxt = (idx_r == '0);
        if (idx_r == '0) begin
          act_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
    end
    if (ser_load) begin
      act_nxt  = 1'b1;
      sign_nxt = stg_data[NUM_STAGES].neg;
      idx_nxt  = lead;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      sign_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      sign_r      <= sign_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_code_r <= oc_nxt;
    out_last_char_r <= ol_nxt;
    if (ser_load) begin
      for (int d = 0; d < int'(NUM_DIGITS); d++) begin
        dig_r[d] <= stg_data[NUM_STAGES].bcd[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_code_r;
  assign out_last_char = out_last_char_r;

`ifndef SYNTHESIS
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CHAR_MINUS ||
                   (out_char_code >= CHAR_ZERO && out_char_code <= CHAR_ZERO + 8'd9)))
    else $error("illegal character code");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_code == CHAR_MINUS) |-> !out_last_char)
    else $error("minus sign marked as last word");

  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && sign_r) |=> (out_valid && out_char_code == CHAR_MINUS))
    else $error("pending sign not sent");

  a_hold_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld[NUM_STAGES] && !ser_free) |=> stg_vld[NUM_STAGES])
    else $error("stalled number dropped");
`endif

endmodule : signed_int_to_decimal_ascii

`default_nettype wire
